// File: hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared definitions for the bitmap block allocator
// status codes, request kinds, field widths and the first-clear-bit helper
// ----------------------------------------------------------------------------
package bba_pkg;

    typedef logic [1:0] status_t;
    typedef logic [7:0] map_byte_t;

    localparam int ID_W          = 10;
    localparam int COUNT_W       = 11;
    localparam int STATUS_W      = 2;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 16;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

    localparam logic MODE_ALLOC  = 1'b0;
    localparam logic MODE_FREE   = 1'b1;

    localparam map_byte_t BYTE_FULL = 8'hff;
    localparam map_byte_t BYTE_MSB  = 8'h80;

    // position of the first clear bit, msb first (0 means bit 7)
    function automatic logic [2:0] first_clear(input map_byte_t b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int j = 7; j >= 0; j--)
        begin
            if (!b[7 - j])
            begin
                pos = 3'(j);
            end
        end
        return pos;
    endfunction

endpackage

// File: hw/rtl/bitmap_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit: first-fit block allocator over a used bitmap
// allocate takes the first clear bit (msb first) of the first non-full byte,
// free clears the bit of the given block
// ----------------------------------------------------------------------------
//
//  channel      dir  signals                       beat contents
//  -----------  ---  ----------------------------  ------------------------------
//  request      in   s_tvalid s_tready s_tdata     tdata[9:0] block_id
//                    s_tuser                       tuser mode (0 alloc, 1 free)
//  result       out  m_tvalid m_tready m_tdata     tdata[1:0] status,
//                                                  tdata[11:2] block_id_res
//  block_count  in   block_count_we                written when we is high
//                    block_count_wdata
//
//  steps: a free reads its byte, clears the bit and writes the byte back; an
//    allocate checks one byte at a time, up to scan_limit bytes (128 with the
//    default map), through the single read port of the bitmap memory
//  reset: after rst_n releases, a clearing pass writes zero to all MAX_BLOCKS/8
//    bytes of the bitmap, s_tready stays low meanwhile
//  stalls: a finished result waits in the output register; the next request
//    is taken meanwhile and only its own result waits for m_tready
//  one request is worked on at a time
//
module bitmap_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,           // block_id[9:0], zero pad
    input  logic                 s_tuser,           // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,           // status[1:0], block_id_res[11:2], pad
    input  logic                 block_count_we,
    input  logic [COUNT_W-1:0]   block_count_wdata
);

    localparam int MAP_BYTES = MAX_BLOCKS / 8;
    localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CNT_W     = $clog2(MAP_BYTES + 1);
    localparam int LIM_W     = (CNT_W > 8) ? CNT_W : 8;

    // scan length, min(block_count/8, map bytes), kept instead of the count
    logic [LIM_W-1:0] scan_limit_reg, scan_limit_next;
    logic [LIM_W-1:0] wr_bytes;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    map_byte_t         ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    map_byte_t         ram_rdata;

    status_t           res_status;
    logic [ID_W-1:0]   res_id;

    assign wr_bytes = LIM_W'(block_count_wdata[COUNT_W-1:3]);

    always_comb
    begin
        scan_limit_next = scan_limit_reg;
        if (block_count_we)
        begin
            if (wr_bytes > LIM_W'(MAP_BYTES))
            begin
                scan_limit_next = LIM_W'(MAP_BYTES);
            end
            else
            begin
                scan_limit_next = wr_bytes;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // block_count resets to 1024, i.e. 128 bytes
            scan_limit_reg <= (MAP_BYTES > 128) ? LIM_W'(128) : LIM_W'(MAP_BYTES);
        end
        else
        begin
            scan_limit_reg <= scan_limit_next;
        end
    end

    bba_map_ram #(
        .DEPTH  (MAP_BYTES),
        .ADDR_W (ADDR_W)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bba_seq #(
        .MAP_BYTES (MAP_BYTES),
        .ADDR_W    (ADDR_W),
        .LIM_W     (LIM_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_mode   (s_tuser),
        .req_id     (s_tdata[ID_W-1:0]),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (res_status),
        .res_id     (res_id),
        .scan_limit (scan_limit_reg),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    // pack result beat, status in the low bits
    assign m_tdata = M_TDATA_W'({res_id, res_status});

endmodule

// File: hw/rtl/bba_map_ram.sv
// ----------------------------------------------------------------------------
// bba_map_ram: bitmap store
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module bba_map_ram
    import bba_pkg::*;
#(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  map_byte_t         wdata,
    input  logic [ADDR_W-1:0] raddr,
    output map_byte_t         rdata
);

    map_byte_t mem [DEPTH];
    map_byte_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/bba_seq.sv
// ----------------------------------------------------------------------------
// bba_seq: request sequencer
// clearing pass, byte scan for allocation, read-modify-write for free,
// result register toward the output stream
// ----------------------------------------------------------------------------
module bba_seq
    import bba_pkg::*;
#(
    parameter int MAP_BYTES = 128,
    parameter int ADDR_W    = 7,
    parameter int LIM_W     = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic              req_mode,
    input  logic [ID_W-1:0]   req_id,
    output logic              res_valid,
    input  logic              res_ready,
    output status_t           res_status,
    output logic [ID_W-1:0]   res_id,
    input  logic [LIM_W-1:0]  scan_limit,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output map_byte_t         ram_wdata,
    output logic [ADDR_W-1:0] ram_raddr,
    input  map_byte_t         ram_rdata
);

    localparam int MAP_BLOCKS = MAP_BYTES * 8;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_FREE_WR = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_RESULT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ID_W-1:0]   id_reg, id_next;
    status_t           pend_status_reg, pend_status_next;
    logic [ID_W-1:0]   pend_id_reg, pend_id_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;

    logic                 accept;
    logic                 in_range;
    logic [ADDR_W+9:0]    id_ext;
    logic [ADDR_W-1:0]    free_addr;
    logic [LIM_W:0]       idx_inc;
    logic [2:0]           pos;
    logic [ADDR_W+12:0]   alloc_num;
    logic                 out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign in_range  = ({22'd0, req_id} < 32'(MAP_BLOCKS));
    assign id_ext    = (ADDR_W + 10)'(req_id);
    assign free_addr = id_ext[ADDR_W+2:3];
    assign idx_inc   = (LIM_W + 1)'(idx_reg) + (LIM_W + 1)'(1);
    assign pos       = first_clear(ram_rdata);
    assign alloc_num = (ADDR_W + 13)'({idx_reg, pos});
    assign out_free  = !out_valid_reg || res_ready;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        id_next          = id_reg;
        pend_status_next = pend_status_reg;
        pend_id_next     = pend_id_reg;
        out_valid_next   = out_valid_reg && !res_ready;
        out_status_next  = out_status_reg;
        out_id_next      = out_id_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_reg;
        ram_wdata        = '0;
        ram_raddr        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg + ADDR_W'(1);
                if (idx_reg == ADDR_W'(MAP_BYTES - 1))
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    id_next = req_id;
                    if (req_mode == MODE_FREE)
                    begin
                        pend_id_next = req_id;
                        if (in_range)
                        begin
                            pend_status_next = ST_OK;
                            idx_next         = free_addr;
                            ram_raddr        = free_addr;
                            state_next       = S_FREE_WR;
                        end
                        else
                        begin
                            pend_status_next = ST_RANGE;
                            state_next       = S_RESULT;
                        end
                    end
                    else
                    begin
                        idx_next = '0;
                        if (scan_limit == '0)
                        begin
                            pend_status_next = ST_FULL;
                            pend_id_next     = '0;
                            state_next       = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_FREE_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata & ~(BYTE_MSB >> id_reg[2:0]);
                state_next = S_RESULT;
            end
            S_SCAN:
            begin
                // next byte is fetched while this one is checked
                ram_raddr = idx_inc[ADDR_W-1:0];
                if (ram_rdata != BYTE_FULL)
                begin
                    ram_we           = 1'b1;
                    ram_wdata        = ram_rdata | (BYTE_MSB >> pos);
                    pend_status_next = ST_OK;
                    pend_id_next     = alloc_num[ID_W-1:0];
                    state_next       = S_RESULT;
                end
                else if (idx_inc == {1'b0, scan_limit})
                begin
                    pend_status_next = ST_FULL;
                    pend_id_next     = '0;
                    state_next       = S_RESULT;
                end
                else
                begin
                    idx_next = idx_inc[ADDR_W-1:0];
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_id_next     = pend_id_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg          <= id_next;
        pend_status_reg <= pend_status_next;
        pend_id_reg     <= pend_id_next;
        out_status_reg  <= out_status_next;
        out_id_reg      <= out_id_next;
    end

    assign res_valid  = out_valid_reg;
    assign res_status = out_status_reg;
    assign res_id     = out_id_reg;

endmodule

// File: hw/rtl/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker: port-level checks for the bitmap block allocator
// watches the top level ports and is bound to it below
// ----------------------------------------------------------------------------
module bba_checker
    import bba_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_FULL ||
                      m_tdata[1:0] == ST_RANGE))
        else $error("undefined status code");

    // a full report carries block number zero and no pad bits
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[11:2] == '0)
        else $error("full report with nonzero block number");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:12] == '0)
        else $error("result pad bits set");

    // no request is taken right after reset, the clearing pass runs first
    a_clear_first: assert property (@(posedge clk)
        !rst_n |=> !s_tready)
        else $error("request taken during clearing pass");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (.*);
